[sv/plcl_pkg.sv]
// Package: shared types and constants of the priority ceiling resource lock.
`default_nettype none
package plcl_pkg;

  localparam int PRIO_W = 8;
  localparam int LINK_W = 4;
  localparam int STATUS_W = 3;
  localparam int TABLE_W = 64;
  localparam int PADDR_W = 5;

  localparam logic [LINK_W-1:0] EMPTY_MARK = 4'd8;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CALL_LEVEL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ID = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ACCESS = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_TOP = 3'd4;

  localparam logic [1:0] REG_CEILING = 2'd0;
  localparam logic [1:0] REG_BASE_PRIO = 2'd1;
  localparam logic [1:0] REG_EXT_CHECKS = 2'd2;

  typedef struct packed {
    logic [TABLE_W-1:0] ceiling_table;
    logic [TABLE_W-1:0] base_priority_table;
    logic               extended_checks;
  } cfg_t;

endpackage
`default_nettype wire

[sv/plcl_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module plcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/plcl_regs.sv]
// APB configuration registers: ceiling table, base priority table, check enable.
`default_nettype none
module plcl_regs
  import plcl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [TABLE_W-1:0] pwdata,
  output logic      [TABLE_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  // Registers sit on 8-byte strides; low address bits select nothing.
  assign reg_index = paddr[4:3];
  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ceiling_table <= '0;
      cfg.base_priority_table <= '0;
      cfg.extended_checks <= 1'b1;
    end else if (wr_en) begin
      case (reg_index)
        REG_CEILING:    cfg.ceiling_table <= pwdata;
        REG_BASE_PRIO:  cfg.base_priority_table <= pwdata;
        REG_EXT_CHECKS: cfg.extended_checks <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_CEILING:    prdata = cfg.ceiling_table;
      REG_BASE_PRIO:  prdata = cfg.base_priority_table;
      REG_EXT_CHECKS: prdata = {{(TABLE_W-1){1'b0}}, cfg.extended_checks};
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[sv/priority_ceiling_resource_lock.sv]
// Top level: priority ceiling resource lock with per-resource and per-task memories.
// Path: a word is registered with its memory reads, then moves to the result register.
// Flow: a new word is taken only when idle, so memory accesses never overlap; a result held back by
//   out_ready keeps the next word in the memory stage and in_ready low until it drains.
// Reset: rst clears control, held flags and stack-head valid bits (empty stacks), and
//   loads the configuration defaults; no clearing pass is needed.
`default_nettype none
module priority_ceiling_resource_lock
  import plcl_pkg::*;
#(
  parameter int RES_NUM = 8,
  parameter int TASK_NUM = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [TABLE_W-1:0] pwdata,
  output logic      [TABLE_W-1:0] prdata,
  output logic                    pready,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               func,
  input  wire logic [7:0]         res_id,
  input  wire logic [2:0]         task_id,
  input  wire logic               in_isr,
  input  wire logic [PRIO_W-1:0]  run_priority,
  input  wire logic [PRIO_W-1:0]  ready_top_priority,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [STATUS_W-1:0]     status,
  output logic [PRIO_W-1:0]       new_priority,
  output logic                    preempt
);

  localparam int RAW = (RES_NUM > 1) ? $clog2(RES_NUM) : 1;
  localparam int TAW = (TASK_NUM > 1) ? $clog2(TASK_NUM) : 1;
  localparam int RES_W = PRIO_W + LINK_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  cfg_t cfg;

  plcl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Control state
  logic state;
  logic state_next;
  logic accept;
  logic finish;

  // Request held for the duration of the memory access
  logic              func_q;
  logic [7:0]        rid_q;
  logic [2:0]        tid_q;
  logic              isr_q;
  logic [PRIO_W-1:0] run_q;
  logic [PRIO_W-1:0] top_q;

  // Per-resource held flags and per-task stack-head valid bits live in flops
  // so that reset empties every stack at once.
  logic [RES_NUM-1:0]  held;
  logic [TASK_NUM-1:0] head_valid;

  // Memory ports
  logic              res_we;
  logic [RES_W-1:0]  res_wdata;
  logic [RES_W-1:0]  res_rdata;
  logic              head_we;
  logic [LINK_W-1:0] head_wdata;
  logic [LINK_W-1:0] head_rdata;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid & in_ready;
  // Complete the word only when the output register can take the result.
  assign finish = (state == S_BUSY) & (~out_valid | out_ready);

  plcl_ram #(
    .WIDTH (RES_W),
    .DEPTH (RES_NUM)
  ) u_res_ram (
    .clk   (clk),
    .we    (res_we),
    .waddr (rid_q[RAW-1:0]),
    .wdata (res_wdata),
    .re    (accept),
    .raddr (res_id[RAW-1:0]),
    .rdata (res_rdata)
  );

  plcl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (TASK_NUM)
  ) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (tid_q[TAW-1:0]),
    .wdata (head_wdata),
    .re    (accept),
    .raddr (task_id[TAW-1:0]),
    .rdata (head_rdata)
  );

  // Decode of the word in flight
  logic              tid_ok;
  logic              rid_ok;
  logic              ext;
  logic [PRIO_W-1:0] ceil_prio;
  logic [PRIO_W-1:0] base_prio;
  logic [LINK_W-1:0] head;
  logic [PRIO_W-1:0] saved_prio;
  logic [LINK_W-1:0] saved_link;
  logic              res_held;
  logic [STATUS_W-1:0] status_next;
  logic [PRIO_W-1:0] newp_next;
  logic              preempt_next;
  logic              do_get;
  logic              do_release;

  always_comb begin
    tid_ok = ({1'b0, tid_q} < 4'(TASK_NUM));
    rid_ok = ({1'b0, rid_q} < 9'(RES_NUM));
    ext = cfg.extended_checks;
    ceil_prio = cfg.ceiling_table[{rid_q[2:0], 3'b000} +: PRIO_W];
    base_prio = cfg.base_priority_table[{tid_q, 3'b000} +: PRIO_W];
    // An unwritten stack head reads as empty.
    head = head_valid[tid_q[TAW-1:0]] ? head_rdata : EMPTY_MARK;
    saved_prio = res_rdata[RES_W-1:LINK_W];
    saved_link = res_rdata[LINK_W-1:0];
    res_held = held[rid_q[RAW-1:0]];

    status_next = ST_OK;
    newp_next = run_q;
    preempt_next = 1'b0;
    do_get = 1'b0;
    do_release = 1'b0;

    if (!tid_ok) begin
      status_next = ST_BAD_ID;
    end else if (ext && isr_q) begin
      status_next = ST_CALL_LEVEL;
    end else if (!rid_ok) begin
      // Out-of-range resource is dropped silently with checks off.
      status_next = ext ? ST_BAD_ID : ST_OK;
    end else if (func_q == FUNC_GET) begin
      if (ext && (res_held || (ceil_prio < base_prio))) begin
        status_next = ST_ACCESS;
      end else begin
        do_get = 1'b1;
        newp_next = (ceil_prio > run_q) ? ceil_prio : run_q;
      end
    end else begin
      if (ext && (head != rid_q[LINK_W-1:0])) begin
        status_next = ST_NOT_TOP;
      end else if (ext && (ceil_prio < base_prio)) begin
        status_next = ST_ACCESS;
      end else begin
        do_release = 1'b1;
        newp_next = saved_prio;
        preempt_next = (saved_prio > top_q);
      end
    end

    res_we = finish & do_get;
    res_wdata = {run_q, head};
    head_we = finish & (do_get | do_release);
    head_wdata = do_get ? rid_q[LINK_W-1:0] : saved_link;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_BUSY;
        end
      end
      S_BUSY: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      held <= '0;
      head_valid <= '0;
    end else begin
      state <= state_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (finish && do_get) begin
        held[rid_q[RAW-1:0]] <= 1'b1;
      end
      if (finish && do_release) begin
        held[rid_q[RAW-1:0]] <= 1'b0;
      end
      if (head_we) begin
        head_valid[tid_q[TAW-1:0]] <= 1'b1;
      end
    end
  end

  // Capture the request word; hold it while the memories answer.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func;
      rid_q <= res_id;
      tid_q <= task_id;
      isr_q <= in_isr;
      run_q <= run_priority;
      top_q <= ready_top_priority;
    end
  end

  // Result register: parts the memory stage from the consumer.
  always_ff @(posedge clk) begin
    if (finish) begin
      status <= status_next;
      new_priority <= newp_next;
      preempt <= preempt_next;
    end
  end

endmodule
`default_nettype wire
